// ----- rtl/core/smp_pkg.sv -----
// Package for the skinning matrix palette: widths, constants, controller
// command and status types and the Q3.12 round/saturate helper. No dependencies.
`default_nettype none
package smp_pkg;
  localparam int unsigned ElemW = 16;
  localparam int unsigned RowW = 64;
  localparam int unsigned IdxW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned AccW = 35;
  localparam int unsigned MaxBonesDefault = 256;

  localparam logic [RowW-1:0] InvRow0Rst = 64'h0000_0000_0000_1000;
  localparam logic [RowW-1:0] InvRow1Rst = 64'h0000_0000_1000_0000;
  localparam logic [RowW-1:0] InvRow2Rst = 64'h0000_1000_0000_0000;
  localparam logic [RowW-1:0] InvRow3Rst = 64'h1000_0000_0000_0000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_MUL, ST_OUT
  } state_e;

  // Which product the datapath is forming.
  typedef enum logic [1:0] {
    PH_GLOBAL, PH_INVG, PH_SKIN
  } phase_e;

  typedef struct packed {
    logic   capture;   // take input item and read parent row 0
    logic   rd_next;   // load next parent row from RAM
    logic   mac;       // one multiply-accumulate step
    phase_e phase;
    logic [1:0] row;   // output row i
    logic [1:0] k;     // inner index
    logic   clear;     // start new accumulation
    logic   store;     // round and write row result
    logic   publish;   // move results to output register
  } smp_cmd_t;

  typedef struct packed {
    logic root;
    logic out_busy;
  } smp_sts_t;

  function automatic logic [ElemW-1:0] round_sat(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] q;
    q = (acc + AccW'(2048)) >>> 12;
    if (q > AccW'(32767)) return 16'h7fff;
    else if (q < -AccW'(32768)) return 16'h8000;
    else return q[ElemW-1:0];
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/skinning_matrix_palette.sv -----
// Channel   Direction  Handshake      Payload
// in        input      valid/stall    first_bone, parent_index, local/offset rows, last_bone
// out       output     valid/stall    bone_index, skinned rows, global rows, last_result
// cfg       input      valid/ready    register index, 64-bit data (inverse rows)
// A bone passes through a capture, 4 parent-row reads, 16 steps of the four
// multiply-accumulate lanes per product (three products, two for a root) and
// an output step.
// Reset clears the counter, controller and output valid; the inverse resets
// to identity. A stalled output holds the block before its next input.
// Top level of the skinning matrix palette; uses smp_pkg, smp_ctrl, smp_datapath.
`default_nettype none
module skinning_matrix_palette import smp_pkg::*; #(
  parameter int unsigned MaxBones = MaxBonesDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [RowW-1:0]  cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             first_bone_i,
  input  wire logic [IdxW-1:0]  parent_index_i,
  input  wire logic [RowW-1:0]  local_row0_i,
  input  wire logic [RowW-1:0]  local_row1_i,
  input  wire logic [RowW-1:0]  local_row2_i,
  input  wire logic [RowW-1:0]  local_row3_i,
  input  wire logic [RowW-1:0]  offset_row0_i,
  input  wire logic [RowW-1:0]  offset_row1_i,
  input  wire logic [RowW-1:0]  offset_row2_i,
  input  wire logic [RowW-1:0]  offset_row3_i,
  input  wire logic             last_bone_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [IdxW-1:0]       bone_index_o,
  output logic [RowW-1:0]       skinned_row0_o,
  output logic [RowW-1:0]       skinned_row1_o,
  output logic [RowW-1:0]       skinned_row2_o,
  output logic [RowW-1:0]       skinned_row3_o,
  output logic [RowW-1:0]       global_row0_o,
  output logic [RowW-1:0]       global_row1_o,
  output logic [RowW-1:0]       global_row2_o,
  output logic [RowW-1:0]       global_row3_o,
  output logic                  last_result_o
);
  smp_cmd_t cmd;
  smp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  smp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .sts_i (sts), .cmd_o (cmd)
  );

  smp_datapath #(.MaxBones(MaxBones)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i (cmd), .sts_o (sts),
    .cfg_we_i (cfg_valid_i), .cfg_idx_i (cfg_index_i), .cfg_data_i (cfg_data_i),
    .first_bone_i, .parent_index_i,
    .local_row0_i, .local_row1_i, .local_row2_i, .local_row3_i,
    .offset_row0_i, .offset_row1_i, .offset_row2_i, .offset_row3_i,
    .last_bone_i, .out_stall_i, .out_valid_o, .bone_index_o,
    .skinned_row0_o, .skinned_row1_o, .skinned_row2_o, .skinned_row3_o,
    .global_row0_o, .global_row1_o, .global_row2_o, .global_row3_o,
    .last_result_o
  );
endmodule
`default_nettype wire

// ----- rtl/core/smp_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module smp_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/core/smp_ctrl.sv -----
// Controller for the skinning matrix palette: sequences the matrix products
// (three, or two for a root bone) and the handshakes. Uses smp_pkg.
`default_nettype none
module smp_ctrl import smp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire smp_sts_t sts_i,
  output smp_cmd_t  cmd_o
);
  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [1:0] row_q, row_d, k_q, k_d, ld_q, ld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_GLOBAL;
      row_q <= '0;
      k_q <= '0;
      ld_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      row_q <= row_d;
      k_q <= k_d;
      ld_q <= ld_d;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    row_d = row_q;
    k_d = k_q;
    ld_d = ld_q;
    cmd_o = '0;
    cmd_o.phase = phase_q;
    cmd_o.row = row_q;
    cmd_o.k = k_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          ld_d = '0;
          row_d = '0;
          k_d = '0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // Parent rows arrive one per cycle from the RAM read register.
        cmd_o.rd_next = 1'b1;
        cmd_o.row = ld_q;
        ld_d = ld_q + 2'd1;
        if (ld_q == 2'd3) begin
          state_d = ST_MUL;
          phase_d = sts_i.root ? PH_INVG : PH_GLOBAL;
        end
      end
      ST_MUL: begin
        cmd_o.mac = 1'b1;
        cmd_o.clear = (k_q == 2'd0);
        cmd_o.store = (k_q == 2'd3);
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          row_d = row_q + 2'd1;
          if (row_q == 2'd3) begin
            unique case (phase_q)
              PH_GLOBAL: phase_d = PH_INVG;
              PH_INVG:   phase_d = PH_SKIN;
              default:   state_d = ST_OUT;
            endcase
          end
        end
      end
      ST_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.publish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_mac_only_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mac |-> state_q == ST_MUL) else $error("mac outside compute");
  a_capture_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == ST_LOAD) else $error("capture without load");
  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> !sts_i.out_busy) else $error("publish onto busy output");
`endif
endmodule
`default_nettype wire

// ----- rtl/core/smp_datapath.sv -----
// Datapath for the skinning matrix palette: input capture, global pose RAM,
// four shared multiply-accumulate lanes and the output register. Uses smp_pkg, smp_ram.
`default_nettype none
module smp_datapath import smp_pkg::*; #(
  parameter int unsigned MaxBones = MaxBonesDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire smp_cmd_t        cmd_i,
  output smp_sts_t             sts_o,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [RowW-1:0] cfg_data_i,
  input  wire logic            first_bone_i,
  input  wire logic [IdxW-1:0] parent_index_i,
  input  wire logic [RowW-1:0] local_row0_i,
  input  wire logic [RowW-1:0] local_row1_i,
  input  wire logic [RowW-1:0] local_row2_i,
  input  wire logic [RowW-1:0] local_row3_i,
  input  wire logic [RowW-1:0] offset_row0_i,
  input  wire logic [RowW-1:0] offset_row1_i,
  input  wire logic [RowW-1:0] offset_row2_i,
  input  wire logic [RowW-1:0] offset_row3_i,
  input  wire logic            last_bone_i,
  input  wire logic            out_stall_i,
  output logic                 out_valid_o,
  output logic [IdxW-1:0]      bone_index_o,
  output logic [RowW-1:0]      skinned_row0_o,
  output logic [RowW-1:0]      skinned_row1_o,
  output logic [RowW-1:0]      skinned_row2_o,
  output logic [RowW-1:0]      skinned_row3_o,
  output logic [RowW-1:0]      global_row0_o,
  output logic [RowW-1:0]      global_row1_o,
  output logic [RowW-1:0]      global_row2_o,
  output logic [RowW-1:0]      global_row3_o,
  output logic                 last_result_o
);
  localparam int unsigned BoneW = $clog2(MaxBones);
  localparam int unsigned AddrW = BoneW + 2;
  localparam int unsigned ParRecip = (MaxBones >= 256) ? 1 : (65536 + MaxBones - 1) / MaxBones;

  logic [RowW-1:0] inv_q [4];
  logic [RowW-1:0] loc_q [4];
  logic [RowW-1:0] off_q [4];
  logic [RowW-1:0] par_q [4];
  logic [RowW-1:0] glb_q [4];
  logic [RowW-1:0] ig_q  [4];
  logic [RowW-1:0] skn_q [4];
  logic [BoneW-1:0] cnt_q, idx_q, parent_q;
  logic root_q, last_q;
  logic signed [AccW-1:0] acc_q [4];
  logic [AddrW-1:0] raddr;
  logic [RowW-1:0] rdata;
  logic [BoneW-1:0] idx_new, parent_new;
  logic [RowW-1:0] a_row, b_row, res_row, wdata;
  logic signed [AccW-1:0] acc_d [4];
  logic signed [2*ElemW-1:0] prod [4];
  logic signed [ElemW-1:0] a_el;
  logic [23:0] par_prod;
  logic [15:0] par_rem;
  logic we, we_prod, we_root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q[0] <= InvRow0Rst;
      inv_q[1] <= InvRow1Rst;
      inv_q[2] <= InvRow2Rst;
      inv_q[3] <= InvRow3Rst;
    end else if (cfg_we_i) begin
      inv_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign idx_new = (first_bone_i || cnt_q == '0) ? '0 : cnt_q;

  // Parent index modulo MaxBones by reciprocal multiplication; exact for any 8-bit index.
  always_comb begin
    par_prod = 24'(parent_index_i) * 24'(ParRecip);
    par_rem = 16'(parent_index_i) - 16'(par_prod[23:16]) * 16'(MaxBones);
  end
  assign parent_new = (MaxBones >= 256) ? BoneW'(parent_index_i) : BoneW'(par_rem);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.capture) begin
      if (last_bone_i) cnt_q <= '0;
      else if (32'(idx_new) == MaxBones - 1) cnt_q <= '0;
      else cnt_q <= idx_new + BoneW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      loc_q <= '{local_row0_i, local_row1_i, local_row2_i, local_row3_i};
      off_q <= '{offset_row0_i, offset_row1_i, offset_row2_i, offset_row3_i};
      idx_q <= idx_new;
      parent_q <= parent_new;
      root_q <= (idx_new == '0);
      last_q <= last_bone_i;
    end
    if (cmd_i.rd_next) par_q[cmd_i.row] <= rdata;
  end

  // Read address is issued in the cycle before its row is captured.
  always_comb begin
    if (cmd_i.capture) raddr = {parent_new, 2'd0};
    else raddr = {parent_q, cmd_i.row + 2'd1};
  end

  // A root bone stores its local rows while the parent rows are fetched.
  assign we_prod = cmd_i.store && cmd_i.phase == PH_GLOBAL;
  assign we_root = cmd_i.rd_next && root_q;
  assign we = we_prod || we_root;
  assign wdata = we_root ? loc_q[cmd_i.row] : res_row;

  smp_ram #(.Width(RowW), .Depth(4 * MaxBones)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i ({idx_q, cmd_i.row}),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Operand A is row i of the left matrix, B is row k of the right one.
  always_comb begin
    unique case (cmd_i.phase)
      PH_GLOBAL: begin a_row = par_q[cmd_i.row]; b_row = loc_q[cmd_i.k]; end
      PH_INVG: begin
        a_row = inv_q[cmd_i.row];
        b_row = root_q ? loc_q[cmd_i.k] : glb_q[cmd_i.k];
      end
      default: begin a_row = ig_q[cmd_i.row]; b_row = off_q[cmd_i.k]; end
    endcase
    a_el = a_row[16*cmd_i.k +: ElemW];
    for (int j = 0; j < 4; j++) begin
      prod[j] = a_el * $signed(b_row[16*j +: ElemW]);
      acc_d[j] = (cmd_i.clear ? '0 : acc_q[j]) + AccW'(prod[j]);
    end
    for (int j = 0; j < 4; j++) res_row[16*j +: ElemW] = round_sat(acc_d[j]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac) acc_q <= acc_d;
    if (cmd_i.store) begin
      unique case (cmd_i.phase)
        PH_GLOBAL: glb_q[cmd_i.row] <= res_row;
        PH_INVG:   ig_q[cmd_i.row] <= res_row;
        default:   skn_q[cmd_i.row] <= res_row;
      endcase
    end
    if (cmd_i.capture && idx_new == '0) begin
      glb_q <= '{local_row0_i, local_row1_i, local_row2_i, local_row3_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (cmd_i.publish) out_valid_o <= 1'b1;
    else if (!out_stall_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      bone_index_o <= IdxW'(idx_q);
      {skinned_row3_o, skinned_row2_o, skinned_row1_o, skinned_row0_o} <=
        {skn_q[3], skn_q[2], skn_q[1], skn_q[0]};
      {global_row3_o, global_row2_o, global_row1_o, global_row0_o} <=
        {glb_q[3], glb_q[2], glb_q[1], glb_q[0]};
      last_result_o <= last_q;
    end
  end

  assign sts_o.root = root_q;
  assign sts_o.out_busy = out_valid_o && out_stall_i;

`ifndef SYNTH
  a_no_store_write_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_prod |-> !root_q) else $error("root bone computed a parent product");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  a_cnt_zero_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.capture && last_bone_i) |=> cnt_q == '0) else $error("counter not restarted");
`endif
endmodule
`default_nettype wire
